// File: src/pwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_pkg: shared types and constants of the angle-wrapping PID controller
// Request and response payloads, register indexes, error mode codes and the
// Q16.16 limits used by the datapath and the port checker.
// ----------------------------------------------------------------------------
package pwa_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_GAIN_P     = 2'd0;
  localparam logic [1:0] REG_GAIN_I     = 2'd1;
  localparam logic [1:0] REG_GAIN_D     = 2'd2;
  localparam logic [1:0] REG_ERROR_MODE = 2'd3;

  // error mode codes (the unused code behaves as plain difference)
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_WRAP  = 2'd1;
  localparam logic [1:0] MODE_SPLIT = 2'd2;

  // pi and 2*pi in Q16.16
  localparam logic signed [31:0] PI_Q32   = 32'sd205887;
  localparam logic signed [34:0] PI_Q     = 35'sd205887;
  localparam logic signed [34:0] TWO_PI_Q = 35'sd411774;

  // signed 32 bit saturation bounds for the error path
  localparam logic signed [34:0] ERR_MAX = 35'sd2147483647;
  localparam logic signed [34:0] ERR_MIN = -35'sd2147483648;

  // integrator limit, +/-3000 in Q16.16
  localparam logic signed [48:0] INT_LIM = 49'sd196608000;

  // output limit, +/-5000 in Q16.16
  localparam logic signed [49:0] OUT_LIM   = 50'sd327680000;
  localparam logic signed [29:0] DRIVE_MAX = 30'sd327680000;

  // command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] target;
    logic signed [31:0] measured;
  } in_req_t;

  typedef struct packed {
    logic signed [29:0] drive;
    logic               clamped;
  } out_rsp_t;

endpackage

// File: src/pid_with_angle_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_angle_wrap: positional PID controller with angle wrap
// Q16.16 PID with three error modes, integrator clamp at +/-3000 and output
// clamp at +/-5000, in a four register pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (cmd, target, measured) enter on the in_valid_i / in_ready_o
//   handshake; one response (drive, clamped) leaves per request on the
//   out_valid_o / out_ready_i handshake, in request order. A clear request
//   zeroes the integrator and the stored error and answers with zero.
//   A request passes the input register, error register, product register
//   and result register before its response shows on the outputs.
//   Throughput: one request per cycle while the receiver does not stall,
//   set by the three parallel 32x32 multipliers and the integrator update
//   in the result stage.
//   Stalls: each stage holds while the stage after it is full and not
//   moving; empty stages still take requests, so in_ready_o drops only when
//   all four registers hold work and the receiver is stalled.
//   Reset: clears all valid flags, the gains, the error mode, the
//   integrator and the stored error. The user writes gains and mode through
//   the cfg port only while the pipeline is empty, not enforced by the block.
// ----------------------------------------------------------------------------
module pid_with_angle_wrap (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pwa_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pwa_pkg::out_rsp_t out_rsp_o
);

  // configuration registers
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic [1:0]         mode_q;

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: captured request
  pwa_pkg::in_req_t req_q;

  // stage 2: error and derivative operand
  logic               clr2_q;
  logic signed [31:0] err_q, dop_q;
  logic signed [31:0] prev_err_q;

  // stage 3: scaled products
  logic               clr3_q;
  logic signed [47:0] pterm_q, iterm_q, dterm_q;

  // stage 4: integrator and result
  logic signed [28:0] isum_q, isum_d;
  pwa_pkg::out_rsp_t  rsp_q, rsp_d;

  // combinational intermediates
  logic signed [34:0] diff, werr;
  logic signed [31:0] err_d, dop_d;
  logic signed [32:0] ddiff;
  logic               t_lt, t_gt, m_lt, m_gt;
  logic signed [63:0] prod_p, prod_i, prod_d;
  logic signed [48:0] isum_w;
  logic signed [49:0] sum_w;

  // pipeline flow control
  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      mode_q   <= pwa_pkg::MODE_PLAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwa_pkg::REG_GAIN_P:     gain_p_q <= cfg_data_i;
        pwa_pkg::REG_GAIN_I:     gain_i_q <= cfg_data_i;
        pwa_pkg::REG_GAIN_D:     gain_d_q <= cfg_data_i;
        pwa_pkg::REG_ERROR_MODE: mode_q   <= cfg_data_i[1:0];
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1 input register
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) req_q <= in_req_i;
  end

  // error forming per mode
  always_comb begin
    diff = 35'(req_q.target) - 35'(req_q.measured);
    t_lt = req_q.target < pwa_pkg::PI_Q32;
    t_gt = req_q.target > pwa_pkg::PI_Q32;
    m_lt = req_q.measured < pwa_pkg::PI_Q32;
    m_gt = req_q.measured > pwa_pkg::PI_Q32;
    werr = diff;
    case (mode_q)
      pwa_pkg::MODE_WRAP: begin
        if (diff > pwa_pkg::PI_Q) werr = diff - pwa_pkg::TWO_PI_Q;
        else if (diff < -pwa_pkg::PI_Q) werr = diff + pwa_pkg::TWO_PI_Q;
      end
      pwa_pkg::MODE_SPLIT: begin
        if ((t_lt && m_lt) || (t_gt && m_gt)) werr = diff;
        else if (t_gt && m_lt) werr = diff - pwa_pkg::TWO_PI_Q;
        else werr = diff + pwa_pkg::TWO_PI_Q;
      end
      default: werr = diff;
    endcase
    if (werr > pwa_pkg::ERR_MAX) err_d = 32'sh7fffffff;
    else if (werr < pwa_pkg::ERR_MIN) err_d = 32'sh80000000;
    else err_d = werr[31:0];
    // derivative operand, saturated
    ddiff = 33'(err_d) - 33'(prev_err_q);
    if (ddiff > 33'sh0_7fffffff) dop_d = 32'sh7fffffff;
    else if (ddiff < -33'sh0_80000000) dop_d = 32'sh80000000;
    else dop_d = ddiff[31:0];
  end

  // stage 2 error register
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      clr2_q <= req_q.cmd;
      err_q  <= err_d;
      dop_q  <= dop_d;
    end
  end

  // stored error of the last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (en2 && v1_q) begin
      prev_err_q <= (req_q.cmd == pwa_pkg::CMD_CLEAR) ? 32'sd0 : err_d;
    end
  end

  // three gain multiplies, floor shift by 16
  assign prod_p = 64'(gain_p_q) * 64'(err_q);
  assign prod_i = 64'(gain_i_q) * 64'(err_q);
  assign prod_d = 64'(gain_d_q) * 64'(dop_q);

  // stage 3 product register
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      clr3_q  <= clr2_q;
      pterm_q <= prod_p[63:16];
      iterm_q <= prod_i[63:16];
      dterm_q <= prod_d[63:16];
    end
  end

  // integrator update and output clamp
  always_comb begin
    isum_w = 49'(isum_q) + 49'(iterm_q);
    if (isum_w > pwa_pkg::INT_LIM) isum_d = 29'(pwa_pkg::INT_LIM);
    else if (isum_w < -pwa_pkg::INT_LIM) isum_d = 29'(-pwa_pkg::INT_LIM);
    else isum_d = isum_w[28:0];
    sum_w = 50'(pterm_q) + 50'(isum_d) + 50'(dterm_q);
    if (sum_w >= pwa_pkg::OUT_LIM) begin
      rsp_d.drive   = pwa_pkg::DRIVE_MAX;
      rsp_d.clamped = 1'b1;
    end else if (sum_w <= -pwa_pkg::OUT_LIM) begin
      rsp_d.drive   = -pwa_pkg::DRIVE_MAX;
      rsp_d.clamped = 1'b1;
    end else begin
      rsp_d.drive   = sum_w[29:0];
      rsp_d.clamped = 1'b0;
    end
    if (clr3_q == pwa_pkg::CMD_CLEAR) begin
      isum_d        = '0;
      rsp_d.drive   = '0;
      rsp_d.clamped = 1'b0;
    end
  end

  // integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isum_q <= '0;
    end else if (en4 && v3_q) begin
      isum_q <= isum_d;
    end
  end

  // stage 4 result register
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) rsp_q <= rsp_d;
  end

  assign out_valid_o = v4_q;
  assign out_rsp_o   = rsp_q;

endmodule

// File: src/pwa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_checker: port-level checks of the angle-wrapping PID controller
// Watches the response channel for handshake holding and for drive values
// that agree with the clamp flag and the output limit.
// ----------------------------------------------------------------------------
module pwa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pwa_pkg::out_rsp_t out_rsp_o
);

  // a stalled response stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // a stalled response keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("response changed while stalled");

  // clamp flag means the drive sits on a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.clamped |->
      (out_rsp_o.drive == pwa_pkg::DRIVE_MAX) || (out_rsp_o.drive == -pwa_pkg::DRIVE_MAX))
    else $error("clamp flag without limit drive");

  // drive never leaves the output range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_rsp_o.drive <= pwa_pkg::DRIVE_MAX) && (out_rsp_o.drive >= -pwa_pkg::DRIVE_MAX))
    else $error("drive outside output limit");

endmodule

bind pid_with_angle_wrap pwa_checker u_pwa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the angle-wrapping PID controller
// Streams control and clear requests through the valid/ready ports under
// random sender bursts and receiver stalls, predicts every response with a
// cycle-free Q16.16 model of the controller and compares drive and clamped
// field by field, over several gain and error mode settings.
// ----------------------------------------------------------------------------
module testbench;

  // fixed point constants of the controller
  localparam longint PI_FIX     = 205887;
  localparam longint TWO_PI_FIX = 411774;
  localparam longint INT_LIMIT  = 64'sd196608000;
  localparam longint OUT_LIMIT  = 64'sd327680000;
  localparam longint S32_HI     = 64'sd2147483647;
  localparam longint S32_LO     = -64'sd2147483648;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STEPS_PER_SETTING = 54;
  localparam int HOLD_CYCLES = 250;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [31:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pwa_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pwa_pkg::out_rsp_t out_rsp;

  // controller state and settings as the model sees them
  longint     kp, ki, kd;
  logic [1:0] err_mode;
  longint     integ_acc, prev_err;

  pwa_pkg::in_req_t  step_queue[$];
  pwa_pkg::out_rsp_t drive_expected[$];
  pwa_pkg::out_rsp_t want_rsp;

  int errors = 0;
  int n_req = 0;
  int n_clear = 0;
  int n_checked = 0;
  int n_out_clamps = 0;
  int n_int_clamps = 0;
  int n_settings = 0;

  // sender burst state and receiver hold-off bookkeeping
  int gap_left = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_window = 0;
  int rx_style = 0;
  int rx_cycle = 0;

  pid_with_angle_wrap u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // q16.16 product, floor of the exact product over 2^16
  function automatic longint fix_mul(longint a, longint b);
    longint prod;
    prod = a * b;
    return prod >>> 16;
  endfunction

  // one controller update, returns the response it should produce
  function automatic pwa_pkg::out_rsp_t control_step(pwa_pkg::in_req_t req);
    longint            tgt, meas, diff, err, p_term, d_term, acc, sum, drive;
    pwa_pkg::out_rsp_t rsp;
    rsp = '0;
    if (req.cmd == pwa_pkg::CMD_CLEAR) begin
      integ_acc = 0;
      prev_err = 0;
      return rsp;
    end
    tgt = $signed(req.target);
    meas = $signed(req.measured);
    diff = tgt - meas;
    case (err_mode)
      pwa_pkg::MODE_WRAP: begin
        if (diff > PI_FIX) diff -= TWO_PI_FIX;
        else if (diff < -PI_FIX) diff += TWO_PI_FIX;
      end
      pwa_pkg::MODE_SPLIT: begin
        if (!((tgt < PI_FIX && meas < PI_FIX) || (tgt > PI_FIX && meas > PI_FIX))) begin
          if (tgt > PI_FIX && meas < PI_FIX) diff -= TWO_PI_FIX;
          else diff += TWO_PI_FIX;
        end
      end
      default: ;
    endcase
    err = clip(diff, S32_LO, S32_HI);
    p_term = fix_mul(kp, err);
    acc = integ_acc + fix_mul(ki, err);
    if (acc > INT_LIMIT || acc < -INT_LIMIT) n_int_clamps++;
    integ_acc = clip(acc, -INT_LIMIT, INT_LIMIT);
    d_term = fix_mul(kd, clip(err - prev_err, S32_LO, S32_HI));
    prev_err = err;
    sum = p_term + integ_acc + d_term;
    if (sum >= OUT_LIMIT) begin
      drive = OUT_LIMIT;
      rsp.clamped = 1'b1;
    end else if (sum <= -OUT_LIMIT) begin
      drive = -OUT_LIMIT;
      rsp.clamped = 1'b1;
    end else begin
      drive = sum;
    end
    rsp.drive = drive[29:0];
    return rsp;
  endfunction

  // operand mix: angles around 0..2pi, pi boundaries, extremes, raw random
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'd413774);
      4, 5:       v = $urandom_range(0, 32'd4000000) - 32'd2000000;
      6:          v = 32'(PI_FIX) - 32'd2 + $urandom_range(0, 4);
      7:          v = $urandom();
      8: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) v = 32'(TWO_PI_FIX) - 32'd3 + $urandom_range(0, 6);
        else v = 32'(-PI_FIX) - 32'd3 + $urandom_range(0, 6);
      end
    endcase
    return v;
  endfunction

  // gain in roughly +/-1.5
  function automatic logic [31:0] small_gain();
    return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
  endfunction

  function automatic void queue_step(logic [31:0] tgt, logic [31:0] meas);
    pwa_pkg::in_req_t r;
    r.cmd = pwa_pkg::CMD_STEP;
    r.target = tgt;
    r.measured = meas;
    step_queue.push_back(r);
  endfunction

  function automatic void queue_clear();
    pwa_pkg::in_req_t r;
    r.cmd = pwa_pkg::CMD_CLEAR;
    r.target = $urandom();
    r.measured = $urandom();
    step_queue.push_back(r);
  endfunction

  function automatic pwa_pkg::in_req_t random_step();
    pwa_pkg::in_req_t r;
    r.cmd = ($urandom_range(0, 19) == 0) ? pwa_pkg::CMD_CLEAR : pwa_pkg::CMD_STEP;
    r.target = pick_value();
    r.measured = pick_value();
    return r;
  endfunction

  // register write, model copy follows at once since the pipe is empty
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      pwa_pkg::REG_GAIN_P:     kp = $signed(data);
      pwa_pkg::REG_GAIN_I:     ki = $signed(data);
      pwa_pkg::REG_GAIN_D:     kd = $signed(data);
      pwa_pkg::REG_ERROR_MODE: err_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic [1:0] mode);
    write_reg(pwa_pkg::REG_GAIN_P, p);
    write_reg(pwa_pkg::REG_GAIN_I, i);
    write_reg(pwa_pkg::REG_GAIN_D, d);
    write_reg(pwa_pkg::REG_ERROR_MODE, {30'd0, mode});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (step_queue.size() != 0 || in_valid || drive_expected.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (step_queue.size() > 0) begin
        in_req <= step_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
                                                   : $urandom_range(10, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall style changes every window, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (rx_window == 0) begin
        rx_window = $urandom_range(20, 80);
        rx_style = $urandom_range(0, 3);
      end else begin
        rx_window--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (rx_cycle % 3 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: check responses in order, then predict newly accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, actual drive %0d clamped %0b",
                   $time, out_rsp.drive, out_rsp.clamped);
        end else begin
          want_rsp = drive_expected.pop_front();
          n_checked++;
          if (want_rsp.clamped) n_out_clamps++;
          if (out_rsp.drive !== want_rsp.drive) begin
            errors++;
            $display("%0t: drive mismatch, expected %0d actual %0d",
                     $time, want_rsp.drive, out_rsp.drive);
          end
          if (out_rsp.clamped !== want_rsp.clamped) begin
            errors++;
            $display("%0t: clamped mismatch, expected %0b actual %0b",
                     $time, want_rsp.clamped, out_rsp.clamped);
          end
        end
      end
      if (in_valid && in_ready) begin
        drive_expected.push_back(control_step(in_req));
        n_req++;
        if (in_req.cmd == pwa_pkg::CMD_CLEAR) n_clear++;
      end
    end
  end

  // stimulus sequence
  initial begin
    kp = 0;
    ki = 0;
    kd = 0;
    err_mode = pwa_pkg::MODE_PLAIN;
    integ_acc = 0;
    prev_err = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // plain difference, saturating error and derivative operand
    load_settings(32'h0001_0000, 32'h0000_2000, 32'h0000_8000, pwa_pkg::MODE_PLAIN);
    queue_clear();
    queue_step(32'd0, 32'd0);
    queue_step(32'h7fff_ffff, 32'h8000_0000);
    queue_step(32'h8000_0000, 32'h7fff_ffff);
    queue_step(32'hffff_ffff, 32'd0);
    queue_step(32'd12345, -32'sd6789);
    queue_clear();
    wait_idle();

    // shortest wrap with extreme gains, both limits hit
    load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, pwa_pkg::MODE_WRAP);
    queue_step(32'(PI_FIX), 32'd0);
    queue_step(32'(PI_FIX + 1), 32'd0);
    queue_step(32'd0, 32'(PI_FIX + 1));
    queue_step(32'd0, 32'(PI_FIX));
    queue_step(32'h7fff_ffff, 32'h8000_0000);
    queue_step(32'h8000_0000, 32'h7fff_ffff);
    wait_idle();

    // split rule: both below, both above, crossing each way, equal to pi
    load_settings(32'hffff_0000, 32'h0000_0100, 32'h0002_0000, pwa_pkg::MODE_SPLIT);
    queue_step(32'd100, 32'd200);
    queue_step(32'(PI_FIX + 5), 32'(PI_FIX + 10));
    queue_step(32'(PI_FIX + 5), 32'd10);
    queue_step(32'd10, 32'(PI_FIX + 5));
    queue_step(32'(PI_FIX), 32'd10);
    queue_step(32'(PI_FIX), 32'(PI_FIX));
    queue_step(32'h7fff_ffff, 32'h8000_0000);
    queue_step(32'h8000_0000, 32'h7fff_ffff);
    wait_idle();

    // unused mode code behaves as plain difference
    load_settings(32'h0001_0000, 32'd0, 32'd0, MODE_UNUSED);
    queue_step(32'd5, 32'd3);
    queue_step(32'h8000_0000, 32'd1);
    wait_idle();

    // random requests over a range of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(small_gain(), small_gain(), small_gain(), pwa_pkg::MODE_PLAIN);
        1: load_settings(small_gain(), small_gain(), small_gain(), pwa_pkg::MODE_WRAP);
        2: load_settings(small_gain(), small_gain(), small_gain(), pwa_pkg::MODE_SPLIT);
        3: load_settings($urandom(), $urandom(), $urandom(), 2'($urandom_range(0, 3)));
        4: load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, pwa_pkg::MODE_WRAP);
        5: load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, pwa_pkg::MODE_SPLIT);
        6: load_settings(small_gain(), 32'd0, small_gain(), MODE_UNUSED);
        default: load_settings(small_gain(), $urandom(), small_gain(), pwa_pkg::MODE_SPLIT);
      endcase
      // long receiver hold-off so the pipe backs up into the input
      if (ph == 2) hold_asks++;
      repeat (STEPS_PER_SETTING) step_queue.push_back(random_step());
      wait_idle();
    end

    repeat (12) @(posedge clk_i);
    $display("ran %0d requests (%0d clears) across %0d gain/mode settings",
             n_req, n_clear, n_settings);
    $display("checked %0d responses, %0d at the output limit, %0d integrator clamps",
             n_checked, n_out_clamps, n_int_clamps);
    if (errors == 0 && drive_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d responses outstanding", drive_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
